// ===== hw/rtl/gsp_pkg.sv =====
package gsp_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SLOTS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_PITCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN_ROLL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_ROLL      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_ROLL      = 3'd7;

  localparam int CFG_DATA_W = 8;

  // Timing constants
  localparam logic [10:0] SLOT_TICKS   = 11'd1757;
  localparam int          CENTER_PULSE = 937;
  localparam int          CENTER_VALUE = 512;
  localparam logic [15:0] PULSE_BIAS   = 16'(CENTER_PULSE - CENTER_VALUE);

  // Reset values
  localparam logic [5:0]  RST_FRAME_SLOTS = 6'd5;
  localparam logic [7:0]  RST_TILT_GAIN   = 8'd40;
  localparam logic [7:0]  RST_LOWER       = 8'd50;
  localparam logic [7:0]  RST_UPPER       = 8'd205;
  localparam logic [9:0]  RST_OFFSET      = 10'd508;
  localparam logic [15:0] RST_LOW_TICKS   = 16'd14063;
  localparam int          RST_CMP_STEP    = 10;

  localparam logic [0:0] CH_PITCH = 1'b0;
  localparam logic [0:0] CH_ROLL  = 1'b1;

  typedef struct packed {
    logic [7:0] gain;
    logic [7:0] lower;
    logic [7:0] upper;
    logic       add;
  } servo_cfg_t;

  typedef struct packed {
    logic [15:0] frame_ticks;
    servo_cfg_t  pitch;
    servo_cfg_t  roll;
  } cfg_t;

  // High-pulse math for one request
  typedef struct packed {
    logic [9:0]  offset;
    logic [15:0] ticks;
    logic [15:0] low_ticks;
    logic [7:0]  position;
  } calc_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] next_compare;
    logic        pin_high;
    logic [7:0]  position;
  } result_t;

endpackage

// ===== hw/rtl/gsp_in_if.sv =====
interface gsp_in_if ();
  logic               valid;
  logic               ready;
  logic               channel;
  logic [7:0]         setpoint;
  logic signed [15:0] tilt_angle;

  modport source (output valid, channel, setpoint, tilt_angle, input ready);
  modport sink   (input valid, channel, setpoint, tilt_angle, output ready);
endinterface

// ===== hw/rtl/gsp_out_if.sv =====
interface gsp_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] phase_ticks;
  logic [15:0] next_compare;
  logic        pin_high;
  logic [7:0]  position;

  modport source (output valid, phase_ticks, next_compare, pin_high, position, input ready);
  modport sink   (input valid, phase_ticks, next_compare, pin_high, position, output ready);
endinterface

// ===== hw/rtl/gsp_cfg_if.sv =====
interface gsp_cfg_if import gsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gsp_cfg_regs.sv =====
module gsp_cfg_regs import gsp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  gsp_cfg_if.sink        cfg_bus,
  output cfg_t           cfg
);

  cfg_t        cfg_r;
  logic [16:0] frame_prod;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  // Keep the frame length in ticks ready, so no multiply sits in the request path
  assign frame_prod = 17'(SLOT_TICKS * cfg_bus.data[5:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_ticks <= 16'(SLOT_TICKS * RST_FRAME_SLOTS);
      cfg_r.pitch       <= '{gain: RST_TILT_GAIN, lower: RST_LOWER, upper: RST_UPPER, add: 1'b0};
      cfg_r.roll        <= '{gain: RST_TILT_GAIN, lower: RST_LOWER, upper: RST_UPPER, add: 1'b0};
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_FRAME_SLOTS:     cfg_r.frame_ticks <= frame_prod[15:0];
        REG_INVERT_MASK: begin
          cfg_r.pitch.add <= cfg_bus.data[0];
          cfg_r.roll.add  <= cfg_bus.data[1];
        end
        REG_TILT_GAIN_PITCH: cfg_r.pitch.gain  <= cfg_bus.data;
        REG_LOWER_PITCH:     cfg_r.pitch.lower <= cfg_bus.data;
        REG_UPPER_PITCH:     cfg_r.pitch.upper <= cfg_bus.data;
        REG_TILT_GAIN_ROLL:  cfg_r.roll.gain   <= cfg_bus.data;
        REG_LOWER_ROLL:      cfg_r.roll.lower  <= cfg_bus.data;
        REG_UPPER_ROLL:      cfg_r.roll.upper  <= cfg_bus.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gsp_servo_calc.sv =====
module gsp_servo_calc import gsp_pkg::*; (
  input  cfg_t               cfg,
  input  logic               channel,
  input  logic [9:0]         offset,
  input  logic [7:0]         setpoint,
  input  logic signed [15:0] tilt_angle,
  output calc_t              calc
);

  servo_cfg_t         sc;
  logic [11:0]        blend;
  logic [9:0]         off_new;
  logic signed [24:0] prod;
  logic signed [24:0] prod_adj;
  logic signed [24:0] quot;
  logic [15:0]        term;
  logic [15:0]        sum;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic signed [15:0] value;

  assign sc = (channel == CH_ROLL) ? cfg.roll : cfg.pitch;

  // Low-pass: (3*offset + 4*setpoint) / 4
  assign blend   = {2'b00, offset} + {1'b0, offset, 1'b0} + {2'b00, setpoint, 2'b00};
  assign off_new = blend[11:2];

  // Tilt term gain*4*angle/256, i.e. gain*angle/64 rounded toward zero
  assign prod     = $signed({1'b0, sc.gain}) * tilt_angle;
  assign prod_adj = prod[24] ? prod + 25'sd63 : prod;
  assign quot     = prod_adj >>> 6;
  assign term     = quot[15:0];

  assign sum = sc.add ? ({6'b0, off_new} + term) : ({6'b0, off_new} - term);

  assign lo = $signed({6'b0, sc.lower, 2'b00});
  assign hi = $signed({6'b0, sc.upper, 2'b00});

  // Lower limit is checked first: when the limits cross, a value below it takes the lower limit and any other the upper
  always_comb begin
    if ($signed(sum) < lo) begin
      value = lo;
    end else if ($signed(sum) > hi) begin
      value = hi;
    end else begin
      value = $signed(sum);
    end
  end

  assign calc.offset    = off_new;
  assign calc.ticks     = value + PULSE_BIAS;
  assign calc.low_ticks = cfg.frame_ticks - calc.ticks;
  assign calc.position  = value[9:2];

endmodule

// ===== hw/rtl/gsp_chan_state.sv =====
module gsp_chan_state import gsp_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  logic       channel,
  input  calc_t      calc,
  output logic [9:0] offset,
  output result_t    result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [9:0]  offset_r  [CHANNELS];
  logic [15:0] low_r     [CHANNELS];
  logic        level_r   [CHANNELS];
  logic [15:0] cmp_r     [CHANNELS];
  logic [7:0]  pos_r     [CHANNELS];
  logic [IDX_W-1:0] idx;
  logic [15:0] ticks;

  assign idx    = IDX_W'(channel);
  assign offset = offset_r[idx];

  // Level low: this match starts the high pulse
  assign ticks = level_r[idx] ? low_r[idx] : calc.ticks;

  assign result.phase_ticks  = ticks;
  assign result.next_compare = cmp_r[idx] + ticks;
  assign result.pin_high     = ~level_r[idx];
  assign result.position     = level_r[idx] ? pos_r[idx] : calc.position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        offset_r[i] <= RST_OFFSET;
        low_r[i]    <= RST_LOW_TICKS;
        level_r[i]  <= 1'b0;
        cmp_r[i]    <= 16'(RST_CMP_STEP * (i + 1));
        pos_r[i]    <= 8'd0;
      end
    end else if (upd) begin
      if (!level_r[idx]) begin
        offset_r[idx] <= calc.offset;
        low_r[idx]    <= calc.low_ticks;
        pos_r[idx]    <= calc.position;
      end
      level_r[idx] <= ~level_r[idx];
      cmp_r[idx]   <= result.next_compare;
    end
  end

endmodule

// ===== hw/rtl/gimbal_servo_pulse_generator.sv =====
// Gimbal servo pulse generator.
// A request held in the input register moves on into the result register when that
//   is free or being drained. Throughput: one request per cycle unless the output stalls;
//   the input register, one pass of the pulse math and the result register form the whole
//   path, with channel state updated in that pass.
// Reset: synchronous, active low; restores flags, settings, per-channel state to defaults.
module gimbal_servo_pulse_generator import gsp_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  gsp_in_if.sink    in_bus,
  gsp_out_if.source out_bus,
  gsp_cfg_if.sink   cfg_bus
);

  cfg_t               cfg;
  calc_t              calc;
  result_t            result;
  result_t            out_r;
  logic [9:0]         offset;

  // Input register
  logic               s1_valid_r;
  logic               s1_channel_r;
  logic [7:0]         s1_setpoint_r;
  logic signed [15:0] s1_angle_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               advance;
  logic               hit;

  gsp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  gsp_servo_calc u_calc (
    .cfg        (cfg),
    .channel    (s1_channel_r),
    .offset     (offset),
    .setpoint   (s1_setpoint_r),
    .tilt_angle (s1_angle_r),
    .calc       (calc)
  );

  gsp_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (advance && hit),
    .channel (s1_channel_r),
    .calc    (calc),
    .offset  (offset),
    .result  (result)
  );

  // Drop requests on channels the build does not have
  assign hit = (int'(s1_channel_r) < CHANNELS);

  // Advance the held request once the result register is free or being drained
  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = hit;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
    end
  end

  // Payload registers: hold until the next stage takes them
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_channel_r  <= in_bus.channel;
      s1_setpoint_r <= in_bus.setpoint;
      s1_angle_r    <= in_bus.tilt_angle;
    end
    if (advance && hit) begin
      out_r <= result;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.phase_ticks  = out_r.phase_ticks;
  assign out_bus.next_compare = out_r.next_compare;
  assign out_bus.pin_high     = out_r.pin_high;
  assign out_bus.position     = out_r.position;

endmodule

// ===== verif/gsp_pulse_checker.sv =====
module gsp_pulse_checker import gsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gsp_in_if    in_mon,
  gsp_out_if   out_mon,
  gsp_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam int PULSE_AT_CENTER = 937;
  localparam int MID_VALUE       = 512;
  localparam int TICKS_PER_SLOT  = 1757;
  localparam int LIMIT_SCALE     = 4;

  logic [5:0]  frame_slots;
  logic [1:0]  invert_mask;
  logic [7:0]  tilt_gain [2];
  logic [7:0]  lower_lim [2];
  logic [7:0]  upper_lim [2];

  logic [9:0]  offset_q   [2];
  logic [15:0] low_len_q  [2];
  logic        level_q    [2];
  logic [15:0] compare_q  [2];
  logic [7:0]  position_q [2];

  result_t phase_due[$];

  // Advance one channel by one compare match and return the phase it starts.
  function automatic result_t next_phase(input logic ch, input logic [7:0] setpoint,
                                         input logic signed [15:0] angle);
    int                 mix;
    int                 term;
    int                 value;
    int                 lo;
    int                 hi;
    logic signed [15:0] wrap16;
    logic [15:0]        ticks;
    result_t            r;
    if (!level_q[ch]) begin
      mix = int'(offset_q[ch]) * 3 + int'(setpoint) * LIMIT_SCALE;
      offset_q[ch] = 10'(mix / 4);
      term = int'(tilt_gain[ch]) * LIMIT_SCALE * int'(angle) / 256;
      wrap16 = term[15:0];
      term = wrap16;
      value = invert_mask[ch] ? int'(offset_q[ch]) + term : int'(offset_q[ch]) - term;
      wrap16 = value[15:0];
      value = wrap16;
      lo = int'(lower_lim[ch]) * LIMIT_SCALE;
      hi = int'(upper_lim[ch]) * LIMIT_SCALE;
      // lower bound is checked first: with crossed limits a value below it takes it, others the upper
      if (value < lo) value = lo;
      else if (value > hi) value = hi;
      ticks = 16'(PULSE_AT_CENTER + value - MID_VALUE);
      low_len_q[ch] = 16'(TICKS_PER_SLOT * int'(frame_slots) - int'(ticks));
      position_q[ch] = 8'(value / LIMIT_SCALE);
      level_q[ch] = 1'b1;
      r.pin_high = 1'b1;
    end else begin
      ticks = low_len_q[ch];
      level_q[ch] = 1'b0;
      r.pin_high = 1'b0;
    end
    compare_q[ch] = compare_q[ch] + ticks;
    r.phase_ticks  = ticks;
    r.next_compare = compare_q[ch];
    r.position     = position_q[ch];
    return r;
  endfunction

  task automatic compare_field(input string field, input int want, input int seen);
    if (want != seen) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      frame_slots = RST_FRAME_SLOTS;
      invert_mask = 2'b00;
      for (int i = 0; i < 2; i++) begin
        tilt_gain[i]  = RST_TILT_GAIN;
        lower_lim[i]  = RST_LOWER;
        upper_lim[i]  = RST_UPPER;
        offset_q[i]   = RST_OFFSET;
        low_len_q[i]  = RST_LOW_TICKS;
        level_q[i]    = 1'b0;
        compare_q[i]  = 16'(RST_CMP_STEP * (i + 1));
        position_q[i] = 8'd0;
      end
      phase_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FRAME_SLOTS:     frame_slots          = cfg_mon.data[5:0];
          REG_INVERT_MASK:     invert_mask          = cfg_mon.data[1:0];
          REG_TILT_GAIN_PITCH: tilt_gain[CH_PITCH]  = cfg_mon.data;
          REG_LOWER_PITCH:     lower_lim[CH_PITCH]  = cfg_mon.data;
          REG_UPPER_PITCH:     upper_lim[CH_PITCH]  = cfg_mon.data;
          REG_TILT_GAIN_ROLL:  tilt_gain[CH_ROLL]   = cfg_mon.data;
          REG_LOWER_ROLL:      lower_lim[CH_ROLL]   = cfg_mon.data;
          REG_UPPER_ROLL:      upper_lim[CH_ROLL]   = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        phase_due.push_back(next_phase(in_mon.channel, in_mon.setpoint, in_mon.tilt_angle));
      if (out_mon.valid && out_mon.ready) begin
        if (phase_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, phase_ticks %0d next_compare %0d",
                   $time, out_mon.phase_ticks, out_mon.next_compare);
        end else begin
          want = phase_due.pop_front();
          compare_field("phase_ticks", want.phase_ticks, out_mon.phase_ticks);
          compare_field("next_compare", want.next_compare, out_mon.next_compare);
          compare_field("pin_high", want.pin_high, out_mon.pin_high);
          compare_field("position", want.position, out_mon.position);
        end
      end
    end
    outstanding = phase_due.size();
  end

endmodule

// ===== verif/gimbal_servo_pulse_generator_tb.sv =====
module gimbal_servo_pulse_generator_tb import gsp_pkg::*; ();

  // long receiver hold-off, in cycles, used to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 300;
  // settling margin after the last result has left, before the next phase begins
  localparam int SETTLE_CYCLES   = 4;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  bit   no_idle;
  bit   hold_off_req;

  gsp_in_if  in_bus ();
  gsp_out_if out_bus ();
  gsp_cfg_if cfg_bus ();

  gimbal_servo_pulse_generator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  gsp_pulse_checker pulse_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle length: mostly none, sometimes short, rarely a long stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one compare match; hold it until the block takes it, then sometimes idle a while.
  task automatic issue_match(input logic ch, input logic [7:0] setpoint,
                             input logic signed [15:0] angle);
    int gap;
    in_bus.valid      <= 1'b1;
    in_bus.channel    <= ch;
    in_bus.setpoint   <= setpoint;
    in_bus.tilt_angle <= angle;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one configuration register write and hold it until it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] frame, input logic [7:0] inv,
                                input logic [7:0] gain_p, input logic [7:0] low_p,
                                input logic [7:0] up_p, input logic [7:0] gain_r,
                                input logic [7:0] low_r, input logic [7:0] up_r);
    write_reg(REG_FRAME_SLOTS, frame);
    write_reg(REG_INVERT_MASK, inv);
    write_reg(REG_TILT_GAIN_PITCH, gain_p);
    write_reg(REG_LOWER_PITCH, low_p);
    write_reg(REG_UPPER_PITCH, up_p);
    write_reg(REG_TILT_GAIN_ROLL, gain_r);
    write_reg(REG_LOWER_ROLL, low_r);
    write_reg(REG_UPPER_ROLL, up_r);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random settings in range; limits are usually ordered, sometimes crossed.
  task automatic shuffle_settings();
    logic [7:0] low_p;
    logic [7:0] low_r;
    logic [7:0] up_p;
    logic [7:0] up_r;
    low_p = 8'($urandom_range(0, 150));
    low_r = 8'($urandom_range(0, 150));
    up_p  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(low_p, 255));
    up_r  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(low_r, 255));
    apply_settings(8'($urandom_range(1, 37)), 8'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)), low_p, up_p,
                   8'($urandom_range(0, 255)), low_r, up_r);
  endtask

  // Random matches: small angles mostly land inside the limits, large ones
  // drive the clamp and the 16-bit wrap of the tilt term.
  task automatic random_matches(input int count);
    int                 pick;
    logic signed [15:0] angle;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        angle = 16'(int'($urandom_range(0, 400)) - 200);
      end else if (pick < 85) begin
        angle = 16'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0:       angle = 16'sh8000;
          1:       angle = 16'sh7fff;
          2:       angle = 16'sh0000;
          default: angle = -16'sd1;
        endcase
      end
      issue_match(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), angle);
    end
  endtask

  // Drop the request line, wait for every result, then let the pipe drain.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random runs of ready and stall, a steady stretch when asked,
  // and one long hold-off so that the block backs up into its input.
  initial begin
    int run;
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (no_idle) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 16);
        out_bus.ready <= 1'b1;
        repeat (run) @(posedge clk);
        run = pick_gap();
        if (run > 0) begin
          out_bus.ready <= 1'b0;
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.channel    <= CH_PITCH;
    in_bus.setpoint   <= 8'd0;
    in_bus.tilt_angle <= 16'sd0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_FRAME_SLOTS;
    cfg_bus.data      <= 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: each channel alternates high pulse and low gap, so
    // issue the extremes in pairs per channel.
    issue_match(CH_PITCH, 8'd0,   16'sh0000);
    issue_match(CH_PITCH, 8'd255, 16'sh7fff);
    issue_match(CH_ROLL,  8'd255, 16'sh7fff);
    issue_match(CH_ROLL,  8'd0,   16'sh8000);
    issue_match(CH_PITCH, 8'd127, 16'sh8000);
    issue_match(CH_PITCH, 8'd127, -16'sd1);
    issue_match(CH_ROLL,  8'd0,   -16'sd1);
    issue_match(CH_ROLL,  8'd255, 16'sd1);
    issue_match(CH_PITCH, 8'd255, 16'sd1);
    issue_match(CH_ROLL,  8'd128, 16'sh8000);
    issue_match(CH_PITCH, 8'd0,   16'sh7fff);
    issue_match(CH_ROLL,  8'd64,  16'sh5555);
    issue_match(CH_PITCH, 8'd170, -16'sd200);
    issue_match(CH_PITCH, 8'd85,  16'sh2aaa);
    settle();

    // One-slot frame, adding tilt, max gains,
    // crossed pitch limits, full-range roll limits.
    apply_settings(8'd1, 8'd3, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    issue_match(CH_PITCH, 8'd0,   16'sh7fff);
    issue_match(CH_ROLL,  8'd255, 16'sh7fff);
    issue_match(CH_PITCH, 8'd255, 16'sh8000);
    issue_match(CH_ROLL,  8'd0,   16'sh8000);
    issue_match(CH_PITCH, 8'd127, -16'sd1);
    issue_match(CH_ROLL,  8'd127, 16'sh8000);
    issue_match(CH_PITCH, 8'd200, 16'sd64);
    issue_match(CH_ROLL,  8'd10,  -16'sd64);
    random_matches(200);
    settle();

    // Longest frame, subtracting tilt, zero and unit gain, crossed roll limits;
    // run it back to back with no idling on either side.
    apply_settings(8'd37, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1, 8'd200, 8'd100);
    no_idle = 1'b1;
    random_matches(200);
    settle();
    no_idle = 1'b0;

    // Random settings; the first of these phases also carries the long hold-off.
    shuffle_settings();
    hold_off_req = 1'b1;
    random_matches(190);
    settle();
    for (int phase = 0; phase < 4; phase++) begin
      shuffle_settings();
      random_matches(190);
      settle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_in_if.sv
hw/rtl/gsp_out_if.sv
hw/rtl/gsp_cfg_if.sv
hw/rtl/gsp_cfg_regs.sv
hw/rtl/gsp_servo_calc.sv
hw/rtl/gsp_chan_state.sv
hw/rtl/gimbal_servo_pulse_generator.sv
verif/gsp_pulse_checker.sv
verif/gimbal_servo_pulse_generator_tb.sv
